>>> sv/sorted_key_table_search_insert_defines.svh
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Concurrent assertion wrappers shared by the RTL of the sorted key table.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_SEARCH_INSERT_DEFINES_SVH
`define SORTED_KEY_TABLE_SEARCH_INSERT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SKT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SKT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKT_ASSERT(lbl, clk, rst, prop, msg)
`define SKT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Sizes, types and link structures shared by the cells and the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_W       = 32;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int GROUP_W     = 16;
  localparam int GROUP_BITS  = $clog2(GROUP_W);
  localparam int GROUP_COUNT = (TABLE_DEPTH + GROUP_W - 1) / GROUP_W;
  localparam int GROUP_SEL_W = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int SLOT_W      = GROUP_SEL_W + GROUP_BITS;
  localparam int PAD_DEPTH   = GROUP_COUNT * GROUP_W;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic lt;
    logic valid;
    key_t key;
  } cell_link_t;

  typedef struct packed {
    logic compare;
    logic insert;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  any_slot;
    logic                  any_eq;
    logic [GROUP_BITS-1:0] idx;
  } group_sum_t;

endpackage

`default_nettype wire

>>> sv/skt_cell.sv
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one key with its valid bit, compares it with the search key and
// takes the search key or its lower neighbour's key on an insertion shift up.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire skt_pkg::cell_ctrl_t ctrl,
  input  wire skt_pkg::key_t      search,
  input  wire skt_pkg::cell_link_t prev,
  output skt_pkg::cell_link_t     link,
  output logic                    eq
);

  logic          lt;
  logic          valid;
  skt_pkg::key_t key;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt    <= 1'b0;
      eq    <= 1'b0;
      valid <= 1'b0;
    end else if (ctrl.compare) begin
      lt <= valid && (key < search);
      eq <= valid && (key == search);
    end else if (ctrl.insert && !lt) begin
      valid <= valid | prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && !ctrl.compare && !lt) begin
      key <= prev.lt ? search : prev.key;
    end
  end

  assign link.lt    = lt;
  assign link.valid = valid;
  assign link.key   = key;

endmodule

`default_nettype wire

>>> sv/skt_group.sv
// ----------------------------------------------------------------------------
// Sorted key table group encoder
// Registers, for one group of cells, whether the insertion slot or a match
// lies in it and the slot's offset within the group.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_group (
  input  wire logic                         clk,
  input  wire logic [skt_pkg::GROUP_W-1:0]  lt_in,
  input  wire logic [skt_pkg::GROUP_W-1:0]  eq_in,
  input  wire logic                         prev_lt,
  output skt_pkg::group_sum_t               sum
);

  logic [skt_pkg::GROUP_W-1:0] boundary;
  skt_pkg::group_sum_t         sum_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < skt_pkg::GROUP_W; i++) begin
      boundary[i] = !lt_in[i] && ((i == 0) ? prev_lt : lt_in[(i == 0) ? 0 : i - 1]);
      if (boundary[i]) begin
        sum_next.idx = sum_next.idx | skt_pkg::GROUP_BITS'(i);
      end
    end
    sum_next.any_slot = |boundary;
    sum_next.any_eq   = |eq_in;
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

`default_nettype wire

>>> sv/sorted_key_table_search_insert.sv
// ----------------------------------------------------------------------------
// Sorted key table with search and insert
// Keeps signed keys in ascending order in a row of cells. A lookup reports
// presence and slot; an add inserts an absent key at its sorted place.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_*       in         tuser: command; tdata: group_key
//  m_*       out        tuser: found, created, table_full; tdata: position,
//                       entry_count
//
//  An item passes these steps from its beat on s_* until its result is held on
//  m_*: compare in every cell, group encoding, final encoding, the shift of
//  the cell row, and loading of the output register. The next beat is taken
//  in the cycle after that load, so only one item is in flight at a time.
//  A stalled m_* side holds the block before that load.
//  Reset empties the table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_key_table_search_insert_defines.svh"

module sorted_key_table_search_insert (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] group_key
  input  wire logic        s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] position, [16:8] entry_count, zero fill
  output logic [2:0]       m_tuser    // [0] found, [1] created, [2] table_full
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_GRP  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic                           cmd;
  skt_pkg::key_t                  search;
  logic [skt_pkg::COUNT_W-1:0]    count;
  skt_pkg::cell_ctrl_t            ctrl;
  skt_pkg::cell_link_t            links [skt_pkg::TABLE_DEPTH];
  logic [skt_pkg::PAD_DEPTH-1:0]  lt_pad;
  logic [skt_pkg::PAD_DEPTH-1:0]  eq_pad;
  logic [skt_pkg::TABLE_DEPTH-1:0] valid_vec;
  skt_pkg::group_sum_t            sums [skt_pkg::GROUP_COUNT];

  logic                           found_c;
  logic                           full_now;
  logic [skt_pkg::SLOT_W-1:0]     slot_c;
  logic                           res_found;
  logic                           res_created;
  logic                           res_full;
  logic [skt_pkg::SLOT_W-1:0]     res_pos;
  logic [skt_pkg::SLOT_W+7:0]     pos_ext;
  logic [skt_pkg::COUNT_W+8:0]    count_ext;

  assign s_tready     = (state == S_IDLE);
  assign ctrl.compare = (state == S_CMP);
  assign ctrl.insert  = (state == S_INS) && res_created;

  for (genvar i = 0; i < skt_pkg::TABLE_DEPTH; i++) begin : g_cell
    skt_pkg::cell_link_t prev;
    if (i == 0) begin : g_first
      assign prev = '{lt: 1'b1, valid: 1'b1, key: '0};
    end else begin : g_rest
      assign prev = links[i-1];
    end
    skt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .search (search),
      .prev   (prev),
      .link   (links[i]),
      .eq     (eq_pad[i])
    );
    assign lt_pad[i]    = links[i].lt;
    assign valid_vec[i] = links[i].valid;
  end

  for (genvar i = skt_pkg::TABLE_DEPTH; i < skt_pkg::PAD_DEPTH; i++) begin : g_pad
    assign lt_pad[i] = 1'b1;
    assign eq_pad[i] = 1'b0;
  end

  for (genvar g = 0; g < skt_pkg::GROUP_COUNT; g++) begin : g_group
    logic prev_lt;
    if (g == 0) begin : g_first
      assign prev_lt = 1'b1;
    end else begin : g_rest
      assign prev_lt = lt_pad[g*skt_pkg::GROUP_W-1];
    end
    skt_group u_group (
      .clk     (clk),
      .lt_in   (lt_pad[g*skt_pkg::GROUP_W +: skt_pkg::GROUP_W]),
      .eq_in   (eq_pad[g*skt_pkg::GROUP_W +: skt_pkg::GROUP_W]),
      .prev_lt (prev_lt),
      .sum     (sums[g])
    );
  end

  always_comb begin
    found_c = 1'b0;
    slot_c  = '0;
    for (int g = 0; g < skt_pkg::GROUP_COUNT; g++) begin
      found_c = found_c | sums[g].any_eq;
      if (sums[g].any_slot) begin
        slot_c = slot_c | {skt_pkg::GROUP_SEL_W'(g), sums[g].idx};
      end
    end
  end

  assign full_now = (count == skt_pkg::COUNT_W'(skt_pkg::TABLE_DEPTH));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_CMP;
      S_CMP:  state_next = S_GRP;
      S_GRP:  state_next = S_FIN;
      S_FIN:  state_next = S_INS;
      S_INS:  state_next = S_OUT;
      S_OUT:  if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.insert) begin
        count <= count + 1'b1;
      end
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd    <= s_tuser;
      search <= $signed(s_tdata);
    end
    if (state == S_FIN) begin
      res_found   <= found_c;
      res_created <= !found_c && cmd && !full_now;
      res_full    <= !found_c && cmd && full_now;
      res_pos     <= (found_c || (cmd && !full_now)) ? slot_c : '0;
    end
  end

  assign pos_ext   = {8'b0, res_pos};
  assign count_ext = {9'b0, count};

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= {res_full, res_created, res_found};
      m_tdata <= {7'b0, count_ext[8:0], pos_ext[7:0]};
    end
  end

  `SKT_ASSERT(a_count_up, clk, rst, (state == S_INS && res_created) |=> (count == $past(count) + 1'b1), "entry count did not grow on an insertion")
  `SKT_ASSERT(a_count_hold, clk, rst, (state == S_INS && !res_created) |=> $stable(count), "entry count changed without an insertion")
  `SKT_ASSERT(a_valid_count, clk, rst, $countones(valid_vec) == 32'(count), "valid cells disagree with the entry count")
  `SKT_ASSERT(a_result_excl, clk, rst, (state == S_FIN) |=> !(res_found && res_created) && !(res_created && res_full), "conflicting result flags")
  `SKT_ASSERT_ALWAYS(a_ready_idle, clk, s_tready |-> !ctrl.insert && !ctrl.compare, "cell row busy while taking a beat")

endmodule

`default_nettype wire

>>> bench/tb_sorted_key_table_search_insert.sv
// ----------------------------------------------------------------------------
// Testbench for the sorted key table with search and insert
// Drives lookup and add commands on the input stream and keeps its own
// sorted copy of the table to predict every result beat. It covers the key
// extremes, the empty and the full table, a long stall of the output side
// and pauses of the input side, with random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_key_table_search_insert;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  typedef enum bit {
    CMD_LOOKUP = 1'b0,
    CMD_ADD    = 1'b1
  } table_cmd_e;

  typedef struct packed {
    logic       found;
    logic       created;
    logic       table_full;
    logic [7:0] position;
    logic [8:0] entry_count;
  } table_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] group_key
  logic        s_tuser;   // [0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] position, [16:8] entry_count, zero fill
  logic [2:0]  m_tuser;   // [0] found, [1] created, [2] table_full

  skt_pkg::key_t held_keys[$];
  table_result_t expected_results[$];
  int            error_count;
  int            cycle_count;
  bit            tx_idle;
  bit            rx_idle;
  bit            hold_request;

  sorted_key_table_search_insert i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic table_result_t predict_table(table_cmd_e cmd, skt_pkg::key_t key);
    table_result_t res;
    int            slot;
    res  = '0;
    slot = 0;
    while (slot < held_keys.size() && held_keys[slot] < key) slot++;
    if (slot < held_keys.size() && held_keys[slot] == key) begin
      res.found    = 1'b1;
      res.position = slot[7:0];
    end else if (cmd == CMD_ADD) begin
      if (held_keys.size() >= skt_pkg::TABLE_DEPTH) begin
        res.table_full = 1'b1;
      end else begin
        held_keys.insert(slot, key);
        res.created  = 1'b1;
        res.position = slot[7:0];
      end
    end
    res.entry_count = 9'(held_keys.size());
    return res;
  endfunction

  function automatic skt_pkg::key_t pick_key();
    int            sel;
    int            n;
    skt_pkg::key_t k;
    sel = $urandom_range(0, 99);
    n   = held_keys.size();
    k   = $urandom;
    if (n > 0 && sel < 60) begin
      k = held_keys[$urandom_range(0, n - 1)];
      if (sel >= 40) k = $urandom_range(0, 1) ? k + 32'sd1 : k - 32'sd1;
    end else if (sel < 70) begin
      case ($urandom_range(0, 5))
        0: k = 32'sh8000_0000;
        1: k = 32'sh8000_0001;
        2: k = 32'sh7fff_ffff;
        3: k = 32'sh7fff_fffe;
        4: k = 32'sd0;
        default: k = -32'sd1;
      endcase
    end
    return k;
  endfunction

  task automatic send_item(input table_cmd_e cmd, input skt_pkg::key_t key);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_table(cmd, key));
  endtask

  task automatic idle_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic send_random(input int count, input int add_pct);
    table_cmd_e cmd;
    repeat (count) begin
      cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_LOOKUP;
      send_item(cmd, pick_key());
    end
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(CMD_LOOKUP, 32'sd0);
    send_item(CMD_ADD,    32'sd0);
    send_item(CMD_ADD,    32'sh7fff_ffff);
    send_item(CMD_ADD,    32'sh8000_0000);
    send_item(CMD_ADD,    -32'sd1);
    send_item(CMD_ADD,    32'sd0);
    send_item(CMD_LOOKUP, 32'sh7fff_ffff);
    send_item(CMD_LOOKUP, 32'sh8000_0000);
    send_item(CMD_LOOKUP, 32'sd5);
    send_item(CMD_ADD,    32'sd100);
    send_item(CMD_ADD,    32'sd50);
    send_item(CMD_ADD,    32'sh8000_0001);
    send_item(CMD_ADD,    32'sh7fff_fffe);
    send_item(CMD_LOOKUP, -32'sd2);
    send_item(CMD_ADD,    32'sh5555_5555);
    send_item(CMD_ADD,    32'shaaaa_aaaa);
    send_item(CMD_LOOKUP, 32'sh5555_5555);
    send_item(CMD_LOOKUP, 32'shaaaa_aaaa);
    send_item(CMD_ADD,    32'sd51);
    send_item(CMD_LOOKUP, 32'sd50);
    idle_input();
  endtask

  task automatic test_random_mixed();
    repeat (13) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      send_random(100, 50);
    end
    idle_input();
  endtask

  task automatic test_output_stall();
    tx_idle      = 1'b0;
    rx_idle      = 1'b1;
    hold_request = 1'b1;
    send_random(60, 50);
    idle_input();
  endtask

  task automatic test_drain_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (4) begin
      send_random(20, 50);
      idle_input();
      wait_for_results();
    end
  endtask

  task automatic test_fill_to_capacity();
    skt_pkg::key_t k;
    tx_idle = 1'b1;
    rx_idle = 1'b0;
    while (held_keys.size() < skt_pkg::TABLE_DEPTH) begin
      k = $urandom;
      send_item(CMD_ADD, k);
    end
    idle_input();
  endtask

  task automatic test_full_table();
    skt_pkg::key_t k;
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    k = $urandom;
    send_item(CMD_ADD, k);
    send_item(CMD_ADD, held_keys[0]);
    send_item(CMD_ADD, held_keys[held_keys.size() - 1]);
    send_item(CMD_LOOKUP, held_keys[skt_pkg::TABLE_DEPTH / 2]);
    k = $urandom;
    send_item(CMD_LOOKUP, k);
    repeat (2) begin
      tx_idle = ($urandom_range(0, 1) != 0);
      rx_idle = ($urandom_range(0, 1) != 0);
      send_random(100, 60);
    end
    idle_input();
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin : receive_loop
      int gap;
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("Result beat with no expectation waiting: tuser %b, tdata %h",
               m_tuser, m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("found",       32'(want.found),       32'(m_tuser[0]));
        check_field("created",     32'(want.created),     32'(m_tuser[1]));
        check_field("table_full",  32'(want.table_full),  32'(m_tuser[2]));
        check_field("position",    32'(want.position),    32'(m_tdata[7:0]));
        check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[16:8]));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    hold_request = 1'b0;
    error_count  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mixed();
    test_output_stall();
    test_drain_pause();
    test_fill_to_capacity();
    test_full_table();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
